// ===== hw/rtl/jssl_pkg.sv =====
// package for the joint setpoint slew limiter
// types, widths, operation and limit codes, register indexes; no dependencies
`default_nettype none

package jssl_pkg;

	localparam int POS_W     = 32;
	localparam int STEP_W    = 31;
	localparam int CFG_W     = (POS_W > STEP_W) ? POS_W : STEP_W;
	localparam int CFG_IDX_W = 2;
	// wide enough for position plus or minus step without wrap
	localparam int SUM_W     = CFG_W + 2;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [STEP_W-1:0]       step_t;

	localparam pos_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam pos_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam step_t STEP_RESET = STEP_W'(1024);

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_SET_ABS  = 2'd1,
		OP_SET_REL  = 2'd2,
		OP_FEEDBACK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		LIMIT_NONE  = 2'd0,
		LIMIT_UPPER = 2'd1,
		LIMIT_LOWER = 2'd2
	} limit_t;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 2'd2;

	typedef struct packed {
		pos_t  upper;
		pos_t  lower;
		step_t max_step;
	} cfg_t;

	typedef struct packed {
		pos_t   cmd;
		logic   accepted;
		logic   moving;
		limit_t hit;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/joint_setpoint_slew_limiter_unit.sv =====
// joint setpoint slew limiter: one item in the input register, one step through
// jssl_datapath, result held in an output register. Channels: in_valid/in_ready
// carry operation and value; out_valid/out_ready carry command_position,
// target_accepted, moving and limit_hit, one result per input transaction.
// An accepted transaction goes into the input register, and its result into the
// result register, where out_valid rises.
// Throughput: one transaction per cycle while the receiver takes results; the only
// loop is the state update in jssl_datapath.
// Configuration: cfg_write with cfg_index and cfg_data writes the upper bound (0),
// the lower bound (1) or max_step (2); write only while idle.
// Reset: limits open to the full position range, max_step 1024, commanded,
// target and measured positions zero, motion idle, both channels empty.
// When the receiver stalls, the result holds in the output register, the next
// item still moves into the input register, and in_ready drops only when both
// registers are full.
`default_nettype none

module joint_setpoint_slew_limiter_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    operation,
	input  wire jssl_pkg::pos_t                value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output jssl_pkg::pos_t                     command_position,
	output logic                               target_accepted,
	output logic                               moving,
	output logic [1:0]                         limit_hit,
	input  wire logic                          cfg_write,
	input  wire logic [jssl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [jssl_pkg::CFG_W-1:0]     cfg_data
);
	import jssl_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	pos_t value_s1;
	logic out_valid_q;
	res_t res_q;
	cfg_t cfg_q;
	res_t res_d;
	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper    <= POS_MAX;
			cfg_q.lower    <= POS_MIN;
			cfg_q.max_step <= STEP_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HIGH_BOUND: cfg_q.upper    <= cfg_data[POS_W-1:0];
				REG_LOW_BOUND:  cfg_q.lower    <= cfg_data[POS_W-1:0];
				REG_MAX_STEP:   cfg_q.max_step <= cfg_data[STEP_W-1:0];
				default:        cfg_q          <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= op_t'(operation);
			value_s1 <= value;
		end
	end

	jssl_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.op      (op_s1),
		.value   (value_s1),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign command_position = res_q.cmd;
	assign target_accepted  = res_q.accepted;
	assign moving           = res_q.moving;
	assign limit_hit        = res_q.hit;

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.accepted |-> res_q.moving)
		else $error("accepted target without motion");

	a_hit_not_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.hit != LIMIT_NONE) |-> !res_q.accepted)
		else $error("limit flag on a set transaction");

	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.hit == LIMIT_NONE) || (res_q.hit == LIMIT_UPPER)
			|| (res_q.hit == LIMIT_LOWER))
		else $error("bad limit code");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost after advance");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q)
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== hw/rtl/jssl_datapath.sv =====
// step logic and motion state of the joint setpoint slew limiter
// uses jssl_pkg; state advances once per transaction taken from the input register
`default_nettype none

module jssl_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire jssl_pkg::op_t  op,
	input  wire jssl_pkg::pos_t value,
	input  wire jssl_pkg::cfg_t cfg,
	output jssl_pkg::res_t      res
);
	import jssl_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(POS_MAX);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(POS_MIN);

	pos_t cmd_q;
	pos_t target_q;
	pos_t meas_q;
	logic active_q;

	logic                    up;
	logic signed [SUM_W-1:0] cmd_ext;
	logic signed [SUM_W-1:0] step_ext;
	logic signed [SUM_W-1:0] tick_sum;
	logic signed [SUM_W-1:0] rel_sum;
	pos_t                    tick_sat;
	pos_t                    tick_aim;
	pos_t                    tick_next;
	limit_t                  tick_hit;
	pos_t                    rel_sat;
	pos_t                    cand;
	logic                    cand_ok;

	pos_t   cmd_d;
	pos_t   target_d;
	pos_t   meas_d;
	logic   active_d;

	always_comb begin
		up       = $signed(target_q) >= $signed(cmd_q);
		cmd_ext  = {{(SUM_W-POS_W){cmd_q[POS_W-1]}}, cmd_q};
		step_ext = {{(SUM_W-STEP_W){1'b0}}, cfg.max_step};
		tick_sum = up ? (cmd_ext + step_ext) : (cmd_ext - step_ext);

		// saturate to position range, then stop at the target
		if (tick_sum > SUM_MAX) begin
			tick_sat = POS_MAX;
		end else if (tick_sum < SUM_MIN) begin
			tick_sat = POS_MIN;
		end else begin
			tick_sat = tick_sum[POS_W-1:0];
		end
		if (up && ($signed(tick_sat) > $signed(target_q))) begin
			tick_aim = target_q;
		end else if (!up && ($signed(tick_sat) < $signed(target_q))) begin
			tick_aim = target_q;
		end else begin
			tick_aim = tick_sat;
		end

		// upper check wins when the limits cross
		if ($signed(tick_aim) > $signed(cfg.upper)) begin
			tick_next = cfg.upper;
			tick_hit  = LIMIT_UPPER;
		end else if ($signed(tick_aim) < $signed(cfg.lower)) begin
			tick_next = cfg.lower;
			tick_hit  = LIMIT_LOWER;
		end else begin
			tick_next = tick_aim;
			tick_hit  = LIMIT_NONE;
		end

		rel_sum = {{(SUM_W-POS_W){meas_q[POS_W-1]}}, meas_q}
			+ {{(SUM_W-POS_W){value[POS_W-1]}}, value};
		if (rel_sum > SUM_MAX) begin
			rel_sat = POS_MAX;
		end else if (rel_sum < SUM_MIN) begin
			rel_sat = POS_MIN;
		end else begin
			rel_sat = rel_sum[POS_W-1:0];
		end

		cand    = (op == OP_SET_REL) ? rel_sat : value;
		cand_ok = !(($signed(cand) > $signed(cfg.upper)) || ($signed(cand) < $signed(cfg.lower)));

		cmd_d        = cmd_q;
		target_d     = target_q;
		meas_d       = meas_q;
		active_d     = active_q;
		res.cmd      = cmd_q;
		res.accepted = 1'b0;
		res.hit      = LIMIT_NONE;

		unique case (op)
			OP_TICK: begin
				if (active_q) begin
					cmd_d    = tick_next;
					active_d = (tick_next != target_q);
					res.cmd  = tick_next;
					res.hit  = tick_hit;
				end else begin
					res.cmd = target_q;
				end
			end
			OP_SET_ABS, OP_SET_REL: begin
				res.accepted = cand_ok;
				if (cand_ok) begin
					target_d = cand;
					active_d = 1'b1;
				end
			end
			OP_FEEDBACK: begin
				meas_d = value;
			end
			default: begin
				meas_d = meas_q;
			end
		endcase
		res.moving = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= '0;
			target_q <= '0;
			meas_q   <= '0;
			active_q <= 1'b0;
		end else if (advance) begin
			cmd_q    <= cmd_d;
			target_q <= target_d;
			meas_q   <= meas_d;
			active_q <= active_d;
		end
	end

endmodule

`default_nettype wire
